/* design/accumulator_machine_step_core_macros.svh */
// Assertion macros for the accumulator machine step core checker.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef ACCUMULATOR_MACHINE_STEP_CORE_MACROS_SVH
`define ACCUMULATOR_MACHINE_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define AMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/ams_pkg.sv */
// Shared types and constants for the accumulator machine step core.
// No dependencies; every other design file but the macros header imports this package.
package ams_pkg;

    localparam int NUM_SLOTS     = 6;
    localparam int PROGRAM_DEPTH = 256;
    localparam int VALUE_BITS    = 16;
    localparam int PC_BITS       = $clog2(PROGRAM_DEPTH);
    localparam int SLOT_IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [PC_BITS-1:0]           pc_t;
    typedef logic [SLOT_IDX_BITS-1:0]     slot_idx_t;

    typedef enum logic [3:0] {
        OP_INBOX     = 4'd0,
        OP_OUTBOX    = 4'd1,
        OP_COPYTO    = 4'd2,
        OP_COPYFROM  = 4'd3,
        OP_ADD       = 4'd4,
        OP_SUB       = 4'd5,
        OP_JUMP      = 4'd6,
        OP_JUMP_ZERO = 4'd7,
        OP_JUMP_NEG  = 4'd8,
        OP_NOP       = 4'd9
    } opcode_t;

    typedef enum logic {
        ACT_EXEC    = 1'b0,
        ACT_PRELOAD = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [3:0]  opcode;
        logic [2:0]  slot;
        logic [7:0]  target;
        logic        inbox_valid;
        value_t      inbox_value;
        value_t      preload_value;
        logic        preload_present;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  next_pc;
        logic        out_valid;
        value_t      out_value;
        logic        took_inbox;
        logic        halted;
        value_t      acc_value;
        logic        acc_holding;
    } out_item_t;

    typedef struct packed {
        pc_t    pc;
        value_t acc;
        logic   holding;
    } arch_state_t;

    typedef struct packed {
        logic      en;
        slot_idx_t idx;
        value_t    value;
        logic      present;
    } slot_wr_t;

endpackage

/* design/ams_req_if.sv */
// Request channel carrying one instruction or slot preload per transaction.
// Depends on ams_pkg for the payload type.
interface ams_req_if import ams_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ams_rsp_if.sv */
// Response channel carrying one step result per transaction.
// Depends on ams_pkg for the payload type.
interface ams_rsp_if import ams_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ams_exec.sv */
// Single-step execute logic: decode, operand select, saturating add/sub, branch.
// Depends on ams_pkg; purely combinational, state lives in the top level.
module ams_exec import ams_pkg::*; (
    input  in_item_t    item,
    input  arch_state_t st,
    input  logic        operand_present,
    input  value_t      operand_value,
    output arch_state_t st_next,
    output slot_wr_t    slot_wr,
    output out_item_t   result
);

    localparam logic signed [VALUE_BITS:0] VMAX = {2'b00, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS:0] VMIN = {2'b11, {(VALUE_BITS-1){1'b0}}};

    logic                    slot_ok;
    value_t                  operand;
    pc_t                     pc_inc;
    pc_t                     tgt;
    logic signed [VALUE_BITS:0] sum;
    value_t                  sum_sat;
    logic                    out_valid;
    value_t                  out_value;
    logic                    took;
    logic                    halt;

    assign slot_ok = int'(item.slot) < NUM_SLOTS;
    assign operand = (slot_ok && operand_present) ? operand_value : '0;
    assign pc_inc  = st.pc + pc_t'(1);
    assign tgt     = pc_t'(item.target);

    always_comb
    begin
        if (opcode_t'(item.opcode) == OP_SUB)
        begin
            sum = {st.acc[VALUE_BITS-1], st.acc} - {operand[VALUE_BITS-1], operand};
        end
        else
        begin
            sum = {st.acc[VALUE_BITS-1], st.acc} + {operand[VALUE_BITS-1], operand};
        end
        if (sum > VMAX)
        begin
            sum_sat = value_t'(VMAX);
        end
        else if (sum < VMIN)
        begin
            sum_sat = value_t'(VMIN);
        end
        else
        begin
            sum_sat = value_t'(sum);
        end
    end

    always_comb
    begin
        st_next         = st;
        st_next.pc      = pc_inc;
        slot_wr.en      = 1'b0;
        slot_wr.idx     = slot_idx_t'(item.slot);
        slot_wr.value   = item.preload_value;
        slot_wr.present = item.preload_present;
        out_valid       = 1'b0;
        out_value       = '0;
        took            = 1'b0;
        halt            = 1'b0;

        if (action_t'(item.action) == ACT_PRELOAD)
        begin
            slot_wr.en = slot_ok;
            st_next.pc = st.pc;
        end
        else
        begin
            unique case (opcode_t'(item.opcode))
                OP_INBOX:
                begin
                    if (item.inbox_valid)
                    begin
                        st_next.acc     = item.inbox_value;
                        st_next.holding = 1'b1;
                        took            = 1'b1;
                    end
                    else
                    begin
                        halt       = 1'b1;
                        st_next.pc = st.pc;
                    end
                end
                OP_OUTBOX:
                begin
                    if (st.holding)
                    begin
                        out_valid       = 1'b1;
                        out_value       = st.acc;
                        st_next.holding = 1'b0;
                    end
                end
                OP_COPYTO:
                begin
                    slot_wr.en      = st.holding && slot_ok;
                    slot_wr.value   = st.acc;
                    slot_wr.present = 1'b1;
                end
                OP_COPYFROM:
                begin
                    if (slot_ok && operand_present)
                    begin
                        st_next.acc     = operand_value;
                        st_next.holding = 1'b1;
                    end
                end
                OP_ADD, OP_SUB:
                begin
                    if (st.holding)
                    begin
                        st_next.acc = sum_sat;
                    end
                end
                OP_JUMP:
                begin
                    st_next.pc = tgt;
                end
                OP_JUMP_ZERO:
                begin
                    if (st.acc == '0)
                    begin
                        st_next.pc = tgt;
                    end
                end
                OP_JUMP_NEG:
                begin
                    if (st.acc < 0)
                    begin
                        st_next.pc = tgt;
                    end
                end
                default:
                begin
                    // nop and undefined codes: advance only
                end
            endcase
        end
    end

    always_comb
    begin
        result.next_pc     = 8'(st_next.pc);
        result.out_valid   = out_valid;
        result.out_value   = out_value;
        result.took_inbox  = took;
        result.halted      = halt;
        result.acc_value   = st_next.acc;
        result.acc_holding = st_next.holding;
    end

endmodule

/* design/accumulator_machine_step_core.sv */
// Channel | Role  | Payload
// --------+-------+----------------------------------------------------
// req     | sink  | in_item_t: one instruction or one scratch slot preload
// rsp     | source| out_item_t: one step result per request
//
// One transaction per cycle while req.ready is high: the step is decoded
// and executed between the request port and a two-entry result queue;
// state updates on acceptance. Each result is queued before rsp shows it.
// req.ready drops only when both queue entries hold unread results.
// Reset clears the PC, accumulator, holding flag and slot presence flags.
// Depends on ams_pkg, ams_req_if, ams_rsp_if and ams_exec.
module accumulator_machine_step_core import ams_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ams_req_if.sink      req,
    ams_rsp_if.source    rsp
);

    pc_t         pc_reg;
    value_t      acc_reg;
    logic        hold_reg;
    value_t      slot_val_mem [NUM_SLOTS];
    logic        slot_pres_reg [NUM_SLOTS];

    arch_state_t st;
    arch_state_t st_next;
    slot_wr_t    slot_wr;
    out_item_t   result;
    slot_idx_t   rd_idx;
    logic        operand_present;
    value_t      operand_value;
    logic        slot_in_range;

    out_item_t   q0_reg;
    out_item_t   q1_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign st.pc      = pc_reg;
    assign st.acc     = acc_reg;
    assign st.holding = hold_reg;

    assign rd_idx        = slot_idx_t'(req.data.slot);
    assign slot_in_range = int'(req.data.slot) < NUM_SLOTS;
    assign operand_present = slot_in_range ? slot_pres_reg[rd_idx] : 1'b0;
    assign operand_value   = slot_in_range ? slot_val_mem[rd_idx] : '0;

    ams_exec u_exec (
        .item            (req.data),
        .st              (st),
        .operand_present (operand_present),
        .operand_value   (operand_value),
        .st_next         (st_next),
        .slot_wr         (slot_wr),
        .result          (result)
    );

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign pop       = rsp.valid && rsp.ready;
    assign rsp.valid = (count_reg != 2'd0);
    assign rsp.data  = q0_reg;

    // Architectural state advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            acc_reg  <= '0;
            hold_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_pres_reg[i] <= 1'b0;
            end
        end
        else if (push)
        begin
            pc_reg   <= st_next.pc;
            acc_reg  <= st_next.acc;
            hold_reg <= st_next.holding;
            if (slot_wr.en)
            begin
                slot_pres_reg[slot_wr.idx] <= slot_wr.present;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && slot_wr.en)
        begin
            slot_val_mem[slot_wr.idx] <= slot_wr.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Result queue: q0 is the head shown on rsp.
    always_ff @(posedge clk)
    begin
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    q0_reg <= result;
                end
                else
                begin
                    q1_reg <= result;
                end
            end
            2'b01:
            begin
                q0_reg <= q1_reg;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    q0_reg <= result;
                end
                else
                begin
                    q0_reg <= q1_reg;
                    q1_reg <= result;
                end
            end
            default:
            begin
                // hold
            end
        endcase
    end

endmodule

/* design/ams_checker.sv */
// Port-level checker for the accumulator machine step core, bound to the top.
// Depends on ams_pkg and accumulator_machine_step_core_macros.svh.
`include "accumulator_machine_step_core_macros.svh"

module ams_checker import ams_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_item_t rsp_data
);

    `AMS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `AMS_ASSERT_IMP(a_halt_excl, rsp_valid && rsp_data.halted, !rsp_data.took_inbox && !rsp_data.out_valid)
    `AMS_ASSERT_IMP(a_out_zero, rsp_valid && !rsp_data.out_valid, rsp_data.out_value == '0)
    `AMS_ASSERT_IMP(a_out_drop, rsp_valid && rsp_data.out_valid, !rsp_data.acc_holding)
    `AMS_ASSERT_IMP(a_inbox_hold, rsp_valid && rsp_data.took_inbox, rsp_data.acc_holding)

endmodule

bind accumulator_machine_step_core ams_checker u_ams_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
